FILE: sv/rwot_pkg.sv
`default_nettype none
package rwot_pkg;

  localparam int MAX_LEN = 4096;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = ADDR_W + 1;

  localparam logic       CMD_PUSH = 1'b0;
  localparam logic       CMD_PULL = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic [1:0] {
    PH_LOADING  = 2'd0,
    PH_EMITTING = 2'd1,
    PH_DONE     = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK,
    ST_RD1,
    ST_RD2,
    ST_PULL_OUT,
    ST_PULL_NONE
  } state_t;

  typedef struct packed {
    logic push;
    logic seek_fail;
    logic seek_step;
    logic rd1;
    logic rd2;
    logic emit;
    logic emit_none;
  } dp_cmd_t;

  typedef struct packed {
    logic emitting;
    logic text_end;
    logic seek_done;
    logic seek_hit;
    logic at_end;
  } dp_stat_t;

  function automatic logic is_word(input logic [7:0] b);
    return (b != CH_SPACE) && (b != CH_TAB) && (b != CH_NL);
  endfunction

endpackage
`default_nettype wire

FILE: sv/rwot_ram.sv
`default_nettype none
module rwot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/rwot_ctrl.sv
`default_nettype none
module rwot_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_cmd,
  input  wire rwot_pkg::dp_stat_t stat,
  output rwot_pkg::dp_cmd_t      cmd,
  output logic                   busy
);
  import rwot_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_cmd == CMD_PUSH) begin
            cmd.push = 1'b1;
            if (stat.text_end) state_nxt = ST_SEEK;
          end else if (stat.emitting) begin
            state_nxt = ST_PULL_OUT;
          end else begin
            state_nxt = ST_PULL_NONE;
          end
        end
      end
      ST_SEEK: begin
        if (stat.seek_done) begin
          cmd.seek_fail = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (stat.seek_hit) begin
          state_nxt = ST_RD1;
        end else begin
          cmd.seek_step = 1'b1;
        end
      end
      ST_RD1: begin
        cmd.rd1   = 1'b1;
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd2   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_PULL_OUT: begin
        cmd.emit  = 1'b1;
        state_nxt = stat.at_end ? ST_SEEK : ST_IDLE;
      end
      ST_PULL_NONE: begin
        cmd.emit_none = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/rwot_dp.sv
`default_nettype none
module rwot_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rwot_pkg::dp_cmd_t cmd,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  output rwot_pkg::dp_stat_t     stat,
  output logic                   out_strobe,
  output logic [7:0]             out_byte,
  output logic                   out_valid,
  output logic                   out_last,
  output logic                   out_truncated
);
  import rwot_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  rc_r, rc_nxt;
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic              ms_r, ms_nxt;
  logic [ADDR_W-1:0] bc_r, bc_nxt;
  logic [CNT_W-1:0]  end_r, end_nxt;
  logic              cls_r, cls_nxt;
  logic              drop_r, drop_nxt;

  logic              t_we, r_we;
  logic [ADDR_W-1:0] t_waddr, r_waddr, r_raddr;
  logic [ADDR_W-1:0] r_wdata;
  logic [7:0]        t_rdata;
  logic [ADDR_W-1:0] r_rdata;

  logic [CNT_W-1:0]  pairs, half, cnt, diff, run_full, run_p1, pc_ext, pc_p1, bc_p1;
  logic              loading, cls, more;
  logic [CNT_W-1:0]  base_len, base_rc;

  rwot_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(in_byte),
    .raddr(bc_r), .rdata_r(t_rdata)
  );

  rwot_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LEN)) u_runs (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata_r(r_rdata)
  );

  always_comb begin
    pairs    = (rc_r + CNT_W'(1)) >> 1;
    half     = rc_r >> 1;
    cnt      = ms_r ? half : pairs;
    pc_ext   = CNT_W'(pc_r);
    pc_p1    = pc_ext + CNT_W'(1);
    diff     = cnt - CNT_W'(1) - pc_ext;
    run_full = {diff[CNT_W-2:0], ms_r};
    run_p1   = run_full + CNT_W'(1);
    bc_p1    = CNT_W'(bc_r) + CNT_W'(1);
    more     = ms_r ? (pc_p1 < pairs) : ((pc_ext < half) || (pc_p1 < pairs));
    r_raddr  = cmd.rd1 ? run_p1[ADDR_W-1:0] : run_full[ADDR_W-1:0];
    loading  = (phase_r == PH_LOADING);
    base_len = loading ? len_r : '0;
    base_rc  = loading ? rc_r : '0;
    cls      = is_word(in_byte);

    stat.emitting  = (phase_r == PH_EMITTING);
    stat.text_end  = (in_byte == 8'd0) || in_last;
    stat.seek_done = (pc_ext >= pairs);
    stat.seek_hit  = (pc_ext < cnt);
    stat.at_end    = (bc_p1 >= end_r);

    out_strobe    = cmd.emit | cmd.emit_none;
    out_valid     = cmd.emit;
    out_byte      = cmd.emit ? t_rdata : 8'd0;
    out_last      = cmd.emit && stat.at_end && !more;
    out_truncated = drop_r;
  end

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    rc_nxt    = rc_r;
    pc_nxt    = pc_r;
    ms_nxt    = ms_r;
    bc_nxt    = bc_r;
    end_nxt   = end_r;
    cls_nxt   = cls_r;
    drop_nxt  = drop_r;
    t_we      = 1'b0;
    t_waddr   = base_len[ADDR_W-1:0];
    r_we      = 1'b0;
    r_waddr   = base_rc[ADDR_W-1:0];
    r_wdata   = base_len[ADDR_W-1:0];

    if (cmd.push) begin
      phase_nxt = PH_LOADING;
      len_nxt   = base_len;
      rc_nxt    = base_rc;
      drop_nxt  = loading ? drop_r : 1'b0;
      if (in_byte != 8'd0) begin
        if (base_len < CNT_W'(MAX_LEN)) begin
          t_we    = 1'b1;
          len_nxt = base_len + CNT_W'(1);
          cls_nxt = cls;
          if (base_len == '0) begin
            r_we    = 1'b1;
            r_waddr = '0;
            r_wdata = '0;
            rc_nxt  = CNT_W'(1);
          end else if (cls != cls_r) begin
            r_we   = 1'b1;
            rc_nxt = base_rc + CNT_W'(1);
          end
        end else begin
          drop_nxt = 1'b1;
        end
      end
      if (stat.text_end) begin
        pc_nxt = '0;
        ms_nxt = 1'b0;
      end
    end

    if (cmd.seek_fail) phase_nxt = PH_DONE;

    if (cmd.seek_step || (cmd.emit && stat.at_end)) begin
      ms_nxt = !ms_r;
      if (ms_r) pc_nxt = pc_r + ADDR_W'(1);
    end

    if (cmd.rd1) bc_nxt = r_rdata;

    if (cmd.rd2) begin
      end_nxt   = (run_p1 < rc_r) ? CNT_W'(r_rdata) : len_r;
      phase_nxt = PH_EMITTING;
    end

    if (cmd.emit) bc_nxt = bc_p1[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LOADING;
      len_r   <= '0;
      rc_r    <= '0;
      pc_r    <= '0;
      ms_r    <= 1'b0;
      bc_r    <= '0;
      drop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      rc_r    <= rc_nxt;
      pc_r    <= pc_nxt;
      ms_r    <= ms_nxt;
      bc_r    <= bc_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r <= end_nxt;
    cls_r <= cls_nxt;
  end

endmodule
`default_nettype wire

FILE: sv/reverse_word_order_text.sv
`default_nettype none
// Byte-serial word-order reverser. Push items (in_cmd = 0) store one nonzero
// text byte each; a zero byte or in_last ends the text and starts a search for
// the last word/separator pair, which holds busy while it runs. Pull items
// (in_cmd = 1) take their byte from the registered read of the text memory, and
// the single result appears on the cycle after the pull is accepted, marked by
// out_strobe; the receiver cannot stall, so it must take every strobed item. A
// pull that finishes a run holds busy while the next run's bounds are read from
// the run-start memory, or while the search finds that no run is left. No
// clearing pass is needed after reset.
module reverse_word_order_text (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_strobe,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic            out_last,
  output logic            out_truncated
);
  import rwot_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rwot_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_cmd(in_cmd),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  rwot_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_byte(in_byte), .in_last(in_last),
    .stat(stat), .out_strobe(out_strobe), .out_byte(out_byte),
    .out_valid(out_valid), .out_last(out_last), .out_truncated(out_truncated)
  );

`ifndef SYNTHESIS
  a_pull_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_PULL) |=> out_strobe)
    else $error("pull item not answered");
  a_push_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_PUSH) |=> !out_strobe)
    else $error("push item produced a result");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result while idle");
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> (out_valid && out_strobe))
    else $error("last without valid byte");
`endif

endmodule
`default_nettype wire
